/* src/rcse_pkg.sv */
// rcse_pkg: shared constants, types and state codes of the relative clock skew estimator
`timescale 1ns / 1ps
package rcse_pkg;

    localparam int LT_W          = 48;
    localparam int SKEW_W        = 32;
    localparam int FRAC_W        = 28;
    localparam int WEIGHT_W      = 16;
    localparam int WINDOW_POINTS = 8;
    localparam int WIN_AW        = (WINDOW_POINTS > 1) ? $clog2(WINDOW_POINTS) : 1;
    localparam int FILL_W        = $clog2(WINDOW_POINTS + 1);
    localparam int SUM_W         = LT_W + WIN_AW;
    localparam int SXY_W         = 2 * LT_W + WIN_AW;
    localparam int CHUNK_W       = (SUM_W + 1) / 2;
    localparam int OPA_W         = 4 * CHUNK_W;
    localparam int OPB_W         = 2 * CHUNK_W;
    localparam int ACC_W         = 2 * LT_W + 2 * WIN_AW + 1;
    localparam int DIV_STEPS     = ACC_W + FRAC_W;
    localparam int DIV_CW        = $clog2(DIV_STEPS);
    localparam int CFG_W         = WEIGHT_W;
    localparam int PT_W          = 2 * LT_W;

    localparam logic [SKEW_W-1:0]   ONE_Q28      = SKEW_W'(64'd1 << FRAC_W);
    localparam logic [SKEW_W-1:0]   SAT_POS      = {1'b0, {(SKEW_W-1){1'b1}}};
    localparam logic [SKEW_W-1:0]   SAT_NEG      = {1'b1, {(SKEW_W-1){1'b0}}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = {1'b1, {(WEIGHT_W-1){1'b0}}};

    // register indexes of the configuration port
    localparam logic CFG_IDX_MODE   = 1'b0;
    localparam logic CFG_IDX_WEIGHT = 1'b1;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic       load;
        logic       issue;
        logic       sub;
        logic       quad;
        logic [1:0] step;
    } mac_ctl_t;

    typedef enum logic [16:0] {
        ST_IDLE      = 17'h00001,
        ST_ONE_RD    = 17'h00002,
        ST_ONE_USE   = 17'h00004,
        ST_SW_RD     = 17'h00008,
        ST_SW_MUL    = 17'h00010,
        ST_SW_END    = 17'h00020,
        ST_SW_SAVE   = 17'h00040,
        ST_FORM      = 17'h00080,
        ST_FORM_END  = 17'h00100,
        ST_FORM_SAVE = 17'h00200,
        ST_CHECK     = 17'h00400,
        ST_DIV       = 17'h00800,
        ST_BL_INIT   = 17'h01000,
        ST_BLEND     = 17'h02000,
        ST_BL_END    = 17'h04000,
        ST_BL_SAVE   = 17'h08000,
        ST_STORE     = 17'h10000
    } state_t;

endpackage

/* src/rcse_ram.sv */
// rcse_ram: generic single-write, single-read memory with registered read data
`timescale 1ns / 1ps
module rcse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/rcse_mac.sv */
// rcse_mac: shared chunked multiplier with a registered product and a wide accumulator
`timescale 1ns / 1ps
module rcse_mac (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rcse_pkg::mac_ctl_t         ctl,
    input  logic [rcse_pkg::ACC_W-1:0] init,
    input  logic [rcse_pkg::OPA_W-1:0] opa,
    input  logic [rcse_pkg::OPB_W-1:0] opb,
    output logic [rcse_pkg::ACC_W-1:0] acc
);

    logic [1:0]                       ia;
    logic                             ib;
    logic [rcse_pkg::CHUNK_W-1:0]     a_chunk;
    logic [rcse_pkg::CHUNK_W-1:0]     b_chunk;
    logic [2*rcse_pkg::CHUNK_W-1:0]   prod;
    logic [2*rcse_pkg::CHUNK_W-1:0]   prod_reg;
    logic [1:0]                       sh_reg;
    logic                             sub_reg;
    logic                             pend_reg;
    logic [rcse_pkg::ACC_W-1:0]       term;
    logic [rcse_pkg::ACC_W-1:0]       acc_reg;
    logic [rcse_pkg::ACC_W-1:0]       acc_next;

    // quad: four chunks of a against the low chunk of b; pair: two by two
    assign ia      = ctl.quad ? ctl.step : {1'b0, ctl.step[0]};
    assign ib      = ctl.quad ? 1'b0 : ctl.step[1];
    assign a_chunk = opa[ia*rcse_pkg::CHUNK_W +: rcse_pkg::CHUNK_W];
    assign b_chunk = opb[ib*rcse_pkg::CHUNK_W +: rcse_pkg::CHUNK_W];
    assign prod    = a_chunk * b_chunk;

    assign term = {{(rcse_pkg::ACC_W-2*rcse_pkg::CHUNK_W){1'b0}}, prod_reg}
                  << (rcse_pkg::CHUNK_W * sh_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.load)
        begin
            acc_next = init;
        end
        else if (pend_reg)
        begin
            acc_next = sub_reg ? (acc_reg - term) : (acc_reg + term);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= ctl.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        sh_reg   <= ia + {1'b0, ib};
        sub_reg  <= ctl.sub;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

/* src/rcse_div.sv */
// rcse_div: one-bit-per-cycle restoring divider giving a saturated signed Q4.28 quotient
`timescale 1ns / 1ps
module rcse_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rcse_pkg::ACC_W-1:0]  num,
    input  logic [rcse_pkg::ACC_W-1:0]  den,
    output logic                        busy,
    output logic                        done,
    output logic [rcse_pkg::SKEW_W-1:0] quot
);

    localparam int DVD_W = rcse_pkg::DIV_STEPS;

    logic                          busy_reg;
    logic                          done_reg;
    logic [rcse_pkg::DIV_CW-1:0]   cnt_reg;
    logic [DVD_W-1:0]              dvd_reg;
    logic [rcse_pkg::ACC_W-1:0]    dvs_reg;
    logic [rcse_pkg::ACC_W-1:0]    rem_reg;
    logic [rcse_pkg::SKEW_W-1:0]   q_reg;
    logic                          big_reg;
    logic                          neg_reg;
    logic [rcse_pkg::ACC_W-1:0]    num_mag;
    logic [rcse_pkg::ACC_W-1:0]    den_mag;
    logic [rcse_pkg::ACC_W:0]      r2;
    logic [rcse_pkg::ACC_W:0]      r2_sub;
    logic                          ge;
    logic [rcse_pkg::SKEW_W:0]     q_wide;

    assign num_mag = num[rcse_pkg::ACC_W-1] ? (~num + 1'b1) : num;
    assign den_mag = den[rcse_pkg::ACC_W-1] ? (~den + 1'b1) : den;

    assign r2     = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge     = r2 >= {1'b0, dvs_reg};
    assign r2_sub = r2 - {1'b0, dvs_reg};
    assign q_wide = {q_reg, ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= rcse_pkg::DIV_CW'(rcse_pkg::DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num_mag, {rcse_pkg::FRAC_W{1'b0}}};
            dvs_reg <= den_mag;
            rem_reg <= '0;
            q_reg   <= '0;
            big_reg <= 1'b0;
            neg_reg <= num[rcse_pkg::ACC_W-1] ^ den[rcse_pkg::ACC_W-1];
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= ge ? r2_sub[rcse_pkg::ACC_W-1:0] : r2[rcse_pkg::ACC_W-1:0];
            q_reg   <= q_wide[rcse_pkg::SKEW_W-1:0];
            // sticky overflow once the quotient passes 32 bits
            big_reg <= big_reg | q_wide[rcse_pkg::SKEW_W];
        end
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            quot = (big_reg || q_reg[rcse_pkg::SKEW_W-1]) ? rcse_pkg::SAT_POS : q_reg;
        end
        else
        begin
            quot = (big_reg || q_reg > rcse_pkg::SAT_NEG) ? rcse_pkg::SAT_NEG
                                                          : (~q_reg + 1'b1);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

/* src/relative_clock_skew_estimator.sv */
// relative_clock_skew_estimator: sequencer, window store and skew state around the shared units
// one request at a time; in_ready is high only while the sequencer is idle
// pairwise mode: most of the time of a request goes to the 131-step divider
// window mode with two or more stored points: the two sweeps use
// the one 26x26 multiplier four times per point, then two forms, the divider and the blend
// a finished result waits in the output register while the next request is taken
// reset: skew 1.0, previous point zero, window empty; window storage is not cleared
`timescale 1ns / 1ps
module relative_clock_skew_estimator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rcse_pkg::LT_W-1:0]     local_time,
    input  logic [rcse_pkg::LT_W-1:0]     global_time,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [rcse_pkg::SKEW_W-1:0] skew_estimate,
    output logic                          zero_denominator,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [rcse_pkg::CFG_W-1:0]    cfg_data
);

    localparam logic [rcse_pkg::ACC_W-1:0] ROUND_HALF =
        rcse_pkg::ACC_W'(1) << (rcse_pkg::WEIGHT_W - 1);

    rcse_pkg::state_t                  state_reg;
    rcse_pkg::state_t                  state_next;
    logic                              mode_reg;
    logic [rcse_pkg::WEIGHT_W-1:0]     weight_reg;
    logic [rcse_pkg::SKEW_W-1:0]       skew_reg;
    logic [rcse_pkg::LT_W-1:0]         prev_l_reg;
    logic [rcse_pkg::LT_W-1:0]         prev_g_reg;
    logic [rcse_pkg::FILL_W-1:0]       fill_reg;
    logic [rcse_pkg::WIN_AW-1:0]       head_reg;
    logic [rcse_pkg::WIN_AW-1:0]       idx_reg;
    logic [1:0]                        cnt_reg;
    logic                              pass_reg;
    logic [1:0]                        fstep_reg;
    logic                              out_valid_reg;

    logic [rcse_pkg::LT_W-1:0]         l_in_reg;
    logic [rcse_pkg::LT_W-1:0]         g_in_reg;
    logic [rcse_pkg::ACC_W-1:0]        num_reg;
    logic [rcse_pkg::ACC_W-1:0]        den_reg;
    logic [rcse_pkg::SUM_W-1:0]        sx_reg;
    logic [rcse_pkg::SUM_W-1:0]        sy_reg;
    logic [rcse_pkg::SXY_W-1:0]        sxy_reg;
    logic [rcse_pkg::SXY_W-1:0]        sxx_reg;
    logic [rcse_pkg::SKEW_W-1:0]       raw_reg;
    logic [rcse_pkg::SKEW_W:0]         dmag_reg;
    logic                              bsub_reg;
    logic                              ok_reg;
    logic [rcse_pkg::SKEW_W-1:0]       skew_out_reg;
    logic                              zden_out_reg;

    logic                              accept;
    logic                              store_go;
    logic                              last_point;
    logic                              full;
    logic [rcse_pkg::FILL_W:0]         slot_sum;
    logic [rcse_pkg::FILL_W:0]         slot_wrap;
    logic [rcse_pkg::WIN_AW-1:0]       wr_slot;
    logic [rcse_pkg::WIN_AW-1:0]       head_inc;
    logic [rcse_pkg::LT_W:0]           d_num;
    logic [rcse_pkg::LT_W:0]           d_den;
    logic [rcse_pkg::SKEW_W:0]         diff;
    logic [rcse_pkg::ACC_W-1:0]        raw_ext;

    logic [rcse_pkg::PT_W-1:0]         rd_data;
    logic [rcse_pkg::LT_W-1:0]         rd_l;
    logic [rcse_pkg::LT_W-1:0]         rd_g;

    rcse_pkg::mac_ctl_t                mac_ctl;
    logic [rcse_pkg::ACC_W-1:0]        mac_init;
    logic [rcse_pkg::OPA_W-1:0]        mac_opa;
    logic [rcse_pkg::OPB_W-1:0]        mac_opb;
    logic [rcse_pkg::ACC_W-1:0]        acc;

    logic                              div_start;
    logic                              div_busy;
    logic                              div_done;
    logic [rcse_pkg::SKEW_W-1:0]       div_quot;

    assign in_ready   = (state_reg == rcse_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign store_go   = (state_reg == rcse_pkg::ST_STORE) && (!out_valid_reg || out_ready);
    assign last_point = (rcse_pkg::FILL_W'(idx_reg) + 1'b1) == fill_reg;
    assign full       = fill_reg == rcse_pkg::FILL_W'(rcse_pkg::WINDOW_POINTS);
    assign rd_l       = rd_data[rcse_pkg::PT_W-1:rcse_pkg::LT_W];
    assign rd_g       = rd_data[rcse_pkg::LT_W-1:0];

    // write slot: after the newest point while filling, over the oldest once full
    assign slot_sum  = (rcse_pkg::FILL_W+1)'(head_reg) + (rcse_pkg::FILL_W+1)'(fill_reg);
    assign slot_wrap = (slot_sum >= (rcse_pkg::FILL_W+1)'(rcse_pkg::WINDOW_POINTS))
                       ? slot_sum - (rcse_pkg::FILL_W+1)'(rcse_pkg::WINDOW_POINTS)
                       : slot_sum;
    assign wr_slot   = full ? head_reg : slot_wrap[rcse_pkg::WIN_AW-1:0];
    assign head_inc  = (head_reg == rcse_pkg::WIN_AW'(rcse_pkg::WINDOW_POINTS - 1))
                       ? '0 : head_reg + 1'b1;

    assign d_num   = {1'b0, global_time} - {1'b0, prev_g_reg};
    assign d_den   = {1'b0, local_time} - {1'b0, prev_l_reg};
    assign diff    = {skew_reg[rcse_pkg::SKEW_W-1], skew_reg}
                     - {raw_reg[rcse_pkg::SKEW_W-1], raw_reg};
    assign raw_ext = {{(rcse_pkg::ACC_W-rcse_pkg::SKEW_W){raw_reg[rcse_pkg::SKEW_W-1]}},
                      raw_reg};

    assign div_start = (state_reg == rcse_pkg::ST_CHECK) && (den_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rcse_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!mode_reg)
                    begin
                        state_next = rcse_pkg::ST_CHECK;
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = rcse_pkg::ST_BL_INIT;
                    end
                    else if (fill_reg == rcse_pkg::FILL_W'(1))
                    begin
                        state_next = rcse_pkg::ST_ONE_RD;
                    end
                    else
                    begin
                        state_next = rcse_pkg::ST_SW_RD;
                    end
                end
            end
            rcse_pkg::ST_ONE_RD:    state_next = rcse_pkg::ST_ONE_USE;
            rcse_pkg::ST_ONE_USE:
            begin
                state_next = (rd_l == '0) ? rcse_pkg::ST_BL_INIT : rcse_pkg::ST_CHECK;
            end
            rcse_pkg::ST_SW_RD:     state_next = rcse_pkg::ST_SW_MUL;
            rcse_pkg::ST_SW_MUL:
            begin
                if (cnt_reg == 2'd3)
                begin
                    state_next = last_point ? rcse_pkg::ST_SW_END : rcse_pkg::ST_SW_RD;
                end
            end
            rcse_pkg::ST_SW_END:    state_next = rcse_pkg::ST_SW_SAVE;
            rcse_pkg::ST_SW_SAVE:
            begin
                state_next = pass_reg ? rcse_pkg::ST_FORM : rcse_pkg::ST_SW_RD;
            end
            rcse_pkg::ST_FORM:
            begin
                if (cnt_reg == 2'd3 && fstep_reg[0])
                begin
                    state_next = rcse_pkg::ST_FORM_END;
                end
            end
            rcse_pkg::ST_FORM_END:  state_next = rcse_pkg::ST_FORM_SAVE;
            rcse_pkg::ST_FORM_SAVE:
            begin
                state_next = fstep_reg[1] ? rcse_pkg::ST_CHECK : rcse_pkg::ST_FORM;
            end
            rcse_pkg::ST_CHECK:
            begin
                state_next = (den_reg == '0) ? rcse_pkg::ST_STORE : rcse_pkg::ST_DIV;
            end
            rcse_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = rcse_pkg::ST_BL_INIT;
                end
            end
            rcse_pkg::ST_BL_INIT:   state_next = rcse_pkg::ST_BLEND;
            rcse_pkg::ST_BLEND:
            begin
                if (cnt_reg == 2'd3)
                begin
                    state_next = rcse_pkg::ST_BL_END;
                end
            end
            rcse_pkg::ST_BL_END:    state_next = rcse_pkg::ST_BL_SAVE;
            rcse_pkg::ST_BL_SAVE:   state_next = rcse_pkg::ST_STORE;
            rcse_pkg::ST_STORE:
            begin
                if (store_go)
                begin
                    state_next = rcse_pkg::ST_IDLE;
                end
            end
            default:                state_next = rcse_pkg::ST_IDLE;
        endcase
    end

    // operand steering for the shared multiplier
    always_comb
    begin
        mac_ctl  = '0;
        mac_init = '0;
        mac_opa  = '0;
        mac_opb  = '0;
        mac_ctl.step = cnt_reg;
        unique case (state_reg) inside
            rcse_pkg::ST_IDLE,
            rcse_pkg::ST_SW_SAVE:
            begin
                mac_ctl.load = 1'b1;
            end
            rcse_pkg::ST_SW_MUL:
            begin
                mac_ctl.issue = 1'b1;
                mac_opa = rcse_pkg::OPA_W'(rd_l);
                mac_opb = pass_reg ? rcse_pkg::OPB_W'(rd_l) : rcse_pkg::OPB_W'(rd_g);
            end
            rcse_pkg::ST_FORM:
            begin
                // n*s first, then minus the product of the two sums
                mac_ctl.issue = 1'b1;
                mac_ctl.quad  = !fstep_reg[0];
                mac_ctl.sub   = fstep_reg[0];
                if (fstep_reg[0])
                begin
                    mac_opa = rcse_pkg::OPA_W'(sx_reg);
                    mac_opb = fstep_reg[1] ? rcse_pkg::OPB_W'(sx_reg)
                                           : rcse_pkg::OPB_W'(sy_reg);
                end
                else
                begin
                    mac_opa = fstep_reg[1] ? rcse_pkg::OPA_W'(sxx_reg)
                                           : rcse_pkg::OPA_W'(sxy_reg);
                    mac_opb = rcse_pkg::OPB_W'(fill_reg);
                end
            end
            rcse_pkg::ST_FORM_SAVE:
            begin
                mac_ctl.load = !fstep_reg[1];
            end
            rcse_pkg::ST_BL_INIT:
            begin
                mac_ctl.load = 1'b1;
                mac_init = (raw_ext << rcse_pkg::WEIGHT_W) + ROUND_HALF;
            end
            rcse_pkg::ST_BLEND:
            begin
                // raw + p*(old - raw), magnitude times weight
                mac_ctl.issue = 1'b1;
                mac_ctl.sub   = bsub_reg;
                mac_opa = rcse_pkg::OPA_W'(dmag_reg);
                mac_opb = rcse_pkg::OPB_W'(weight_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcse_pkg::ST_IDLE;
            mode_reg      <= 1'b0;
            weight_reg    <= rcse_pkg::WEIGHT_RESET;
            skew_reg      <= rcse_pkg::ONE_Q28;
            prev_l_reg    <= '0;
            prev_g_reg    <= '0;
            fill_reg      <= '0;
            head_reg      <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            pass_reg      <= 1'b0;
            fstep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    rcse_pkg::CFG_IDX_MODE:   mode_reg   <= cfg_data[0];
                    rcse_pkg::CFG_IDX_WEIGHT: weight_reg <= cfg_data[rcse_pkg::WEIGHT_W-1:0];
                endcase
            end

            if (store_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                rcse_pkg::ST_IDLE:
                begin
                    idx_reg  <= (fill_reg == rcse_pkg::FILL_W'(1)) ? head_reg : '0;
                    pass_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                rcse_pkg::ST_SW_RD:
                begin
                    cnt_reg <= '0;
                end
                rcse_pkg::ST_SW_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 2'd3 && !last_point)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                rcse_pkg::ST_SW_SAVE:
                begin
                    pass_reg  <= 1'b1;
                    idx_reg   <= '0;
                    cnt_reg   <= '0;
                    fstep_reg <= '0;
                end
                rcse_pkg::ST_FORM:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 2'd3 && !fstep_reg[0])
                    begin
                        fstep_reg <= fstep_reg + 1'b1;
                    end
                end
                rcse_pkg::ST_FORM_SAVE:
                begin
                    fstep_reg <= 2'd2;
                    cnt_reg   <= '0;
                end
                rcse_pkg::ST_BL_INIT:
                begin
                    cnt_reg <= '0;
                end
                rcse_pkg::ST_BLEND:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                rcse_pkg::ST_BL_SAVE:
                begin
                    // floor of the rounded blend over 2^16
                    skew_reg <= acc[rcse_pkg::WEIGHT_W +: rcse_pkg::SKEW_W];
                end
                rcse_pkg::ST_STORE:
                begin
                    if (store_go)
                    begin
                        prev_l_reg    <= l_in_reg;
                        prev_g_reg    <= g_in_reg;
                        if (full)
                        begin
                            head_reg <= head_inc;
                        end
                        else
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rcse_pkg::ST_IDLE:
            begin
                l_in_reg <= local_time;
                g_in_reg <= global_time;
                ok_reg   <= 1'b1;
                raw_reg  <= rcse_pkg::ONE_Q28;
                sx_reg   <= '0;
                sy_reg   <= '0;
                num_reg  <= {{(rcse_pkg::ACC_W-rcse_pkg::LT_W-1){d_num[rcse_pkg::LT_W]}}, d_num};
                den_reg  <= {{(rcse_pkg::ACC_W-rcse_pkg::LT_W-1){d_den[rcse_pkg::LT_W]}}, d_den};
            end
            rcse_pkg::ST_ONE_USE:
            begin
                num_reg <= rcse_pkg::ACC_W'(rd_g);
                den_reg <= rcse_pkg::ACC_W'(rd_l);
            end
            rcse_pkg::ST_SW_MUL:
            begin
                if (cnt_reg == 2'd0 && !pass_reg)
                begin
                    sx_reg <= sx_reg + rcse_pkg::SUM_W'(rd_l);
                    sy_reg <= sy_reg + rcse_pkg::SUM_W'(rd_g);
                end
            end
            rcse_pkg::ST_SW_SAVE:
            begin
                if (pass_reg)
                begin
                    sxx_reg <= acc[rcse_pkg::SXY_W-1:0];
                end
                else
                begin
                    sxy_reg <= acc[rcse_pkg::SXY_W-1:0];
                end
            end
            rcse_pkg::ST_FORM_SAVE:
            begin
                if (fstep_reg[1])
                begin
                    den_reg <= acc;
                end
                else
                begin
                    num_reg <= acc;
                end
            end
            rcse_pkg::ST_CHECK:
            begin
                ok_reg <= (den_reg != '0);
            end
            rcse_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    raw_reg <= div_quot;
                end
            end
            rcse_pkg::ST_BL_INIT:
            begin
                bsub_reg <= diff[rcse_pkg::SKEW_W];
                dmag_reg <= diff[rcse_pkg::SKEW_W] ? (~diff + 1'b1) : diff;
            end
            rcse_pkg::ST_STORE:
            begin
                if (store_go)
                begin
                    skew_out_reg <= skew_reg;
                    zden_out_reg <= !ok_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    rcse_ram #(
        .WIDTH (rcse_pkg::PT_W),
        .DEPTH (rcse_pkg::WINDOW_POINTS)
    ) u_window (
        .clk   (clk),
        .we    (store_go),
        .waddr (wr_slot),
        .wdata ({l_in_reg, g_in_reg}),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    rcse_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .init  (mac_init),
        .opa   (mac_opa),
        .opb   (mac_opb),
        .acc   (acc)
    );

    rcse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid        = out_valid_reg;
    assign skew_estimate    = skew_out_reg;
    assign zero_denominator = zden_out_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while another is in progress");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= rcse_pkg::FILL_W'(rcse_pkg::WINDOW_POINTS))
        else $error("window fill beyond its depth");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_zero_den_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rcse_pkg::ST_STORE && !ok_reg) |-> $stable(skew_reg))
        else $error("skew changed on a zero denominator");

endmodule
